[rtl/go_back_n_sender_unit_assert.svh]
// ---------------------------------------------------------------------------
// Go-Back-N sender assertion macros
// Shorthand for the concurrent checks used in the sender's RTL.
// ---------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_UNIT_ASSERT_SVH
`define GO_BACK_N_SENDER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define GBN_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define GBN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/gbn_pkg.sv]
// ---------------------------------------------------------------------------
// gbn_pkg
// Field widths, codes and shared types of the Go-Back-N sender.
// ---------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

   // Fixed field widths of the item channels
   localparam int FUNC_W    = 2;
   localparam int DATA_W    = 32;
   localparam int SEQ_W     = 3;
   localparam int KIND_W    = 2;
   localparam int TCMD_W    = 2;

   // Request codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_SEND    = 2'd0,
      FUNC_ACK     = 2'd1,
      FUNC_TIMEOUT = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_NEW     = 2'd0,
      KIND_REFUSED = 2'd1,
      KIND_STATUS  = 2'd2,
      KIND_RETX    = 2'd3
   } kind_type;

   // Timer commands
   typedef enum logic [TCMD_W-1:0] {
      TMR_NONE    = 2'd0,
      TMR_START   = 2'd1,
      TMR_STOP    = 2'd2,
      TMR_RESTART = 2'd3
   } timer_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   // One result item as held in the output register
   typedef struct packed {
      kind_type          out_kind;
      logic [SEQ_W-1:0]  seq_num;
      logic [DATA_W-1:0] packet_data;
      timer_type         timer_cmd;
      logic [SEQ_W-1:0]  timer_seq;
      logic              ack_taken;
      logic              window_full;
      logic              last;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/gbn_if.sv]
// ---------------------------------------------------------------------------
// gbn_req_if / gbn_rsp_if
// Valid/ready item channels of the Go-Back-N sender.
// ---------------------------------------------------------------------------
`default_nettype none

interface gbn_req_if
   import gbn_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DATA_W-1:0] payload;
   logic [SEQ_W-1:0]  ack_num;
   logic              ack_ok;

   modport source (output valid, func, payload, ack_num, ack_ok, input ready);
   modport sink   (input valid, func, payload, ack_num, ack_ok, output ready);
endinterface

interface gbn_rsp_if
   import gbn_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] out_kind;
   logic [SEQ_W-1:0]  seq_num;
   logic [DATA_W-1:0] packet_data;
   logic [TCMD_W-1:0] timer_cmd;
   logic [SEQ_W-1:0]  timer_seq;
   logic              ack_taken;
   logic              window_full;
   logic              last;

   modport source (output valid, out_kind, seq_num, packet_data, timer_cmd, timer_seq,
                   ack_taken, window_full, last, input ready);
   modport sink   (input valid, out_kind, seq_num, packet_data, timer_cmd, timer_seq,
                   ack_taken, window_full, last, output ready);
endinterface

`default_nettype wire

[rtl/gbn_store.sv]
// ---------------------------------------------------------------------------
// gbn_store
// Packet store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module gbn_store #(
   parameter int DEPTH = 8,
   parameter int AW    = 3,
   parameter int DW    = 32
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/go_back_n_sender_unit.sv]
// ---------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-Back-N ARQ sender: sliding window over a payload store indexed by
// sequence number, cumulative acks, go-back retransmission on timeout.
// ---------------------------------------------------------------------------
//
//   channel  | dir | handshake      | content
//   ---------+-----+----------------+--------------------------------------
//   req_ch   | in  | valid / ready  | func, payload, ack_num, ack_ok
//   rsp_ch   | out | valid / ready  | kind, seq, data, timer cmd, flags
//
// Send, ack, idle timeout and unused codes: one item per cycle while the output
// register is free, one result each. Timeout with packets outstanding: each packet
// takes a store read (FETCH), then an output load (EMIT, waits for a free slot); req stays low meanwhile.
// Results sit in an output register; req is taken while a result waits if
// rsp.ready is high in the same cycle. Synchronous reset, no clearing pass:
// store entries are only read after their send wrote them.
// ---------------------------------------------------------------------------
`default_nettype none
`include "go_back_n_sender_unit_assert.svh"

module go_back_n_sender_unit
   import gbn_pkg::*;
#(
   parameter int WINDOW       = 4,
   parameter int SEQ_SPACE    = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input wire logic clock,
   input wire logic reset,
   gbn_req_if.sink   req_ch,
   gbn_rsp_if.source rsp_ch
);

   localparam int SeqW   = $clog2(SEQ_SPACE);
   localparam int CntW   = $clog2(WINDOW + 1);
   localparam int StoreW = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
   localparam int CmpA   = (SeqW + 1 > SEQ_W) ? SeqW + 1 : SEQ_W;
   localparam int CmpW   = (CmpA > CntW) ? CmpA : CntW;
   localparam logic [SeqW-1:0] SeqLast = SeqW'(SEQ_SPACE - 1);

   // control state
   state_type       state_ff,     state_in;
   logic [SeqW-1:0] base_ff,      base_in;
   logic [SeqW-1:0] next_ff,      next_in;
   logic [CntW-1:0] in_flight_ff, in_flight_in;
   logic            full_ff,      full_in;
   logic [SeqW-1:0] rd_ptr_ff,    rd_ptr_in;
   logic [CntW-1:0] retx_cnt_ff,  retx_cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_ff,       rsp_in;

   // store ports
   logic              wr_en;
   logic [SeqW-1:0]   wr_addr;
   logic [StoreW-1:0] wr_data;
   logic              rd_en;
   logic [SeqW-1:0]   rd_addr;
   logic [StoreW-1:0] rd_data;

   // item decode helpers
   logic              slot_free;
   logic              req_fire;
   logic [StoreW-1:0] payload_n;
   logic [SeqW-1:0]   next_inc;
   logic [SeqW-1:0]   rd_ptr_inc;
   logic [CmpW-1:0]   ack_ext;
   logic              ack_in_range;
   logic [SeqW-1:0]   ack_seq;
   logic [CmpW-1:0]   ack_off;
   logic              ack_hit;
   logic [SeqW-1:0]   ack_base;
   logic [CntW-1:0]   ack_flight;
   logic [CntW-1:0]   flight_inc;
   logic              retx_last;

   gbn_store #(
      .DEPTH (SEQ_SPACE),
      .AW    (SeqW),
      .DW    (StoreW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshake
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // sequence arithmetic, wraps at SEQ_SPACE
   assign payload_n  = StoreW'(req_ch.payload);
   assign next_inc   = (next_ff == SeqLast) ? '0 : next_ff + SeqW'(1);
   assign rd_ptr_inc = (rd_ptr_ff == SeqLast) ? '0 : rd_ptr_ff + SeqW'(1);
   assign flight_inc = in_flight_ff + CntW'(1);

   // ack window check: offset of ack from base, modulo SEQ_SPACE
   assign ack_ext      = CmpW'(req_ch.ack_num);
   assign ack_in_range = ack_ext < CmpW'(SEQ_SPACE);
   assign ack_seq      = SeqW'(req_ch.ack_num);
   assign ack_off      = (ack_seq >= base_ff)
                       ? CmpW'(ack_seq) - CmpW'(base_ff)
                       : CmpW'(ack_seq) + CmpW'(SEQ_SPACE) - CmpW'(base_ff);
   assign ack_hit      = req_ch.ack_ok && ack_in_range && (in_flight_ff != '0)
                       && (ack_off < CmpW'(in_flight_ff));
   assign ack_base     = (ack_seq == SeqLast) ? '0 : ack_seq + SeqW'(1);
   assign ack_flight   = CntW'(CmpW'(in_flight_ff) - ack_off - CmpW'(1));

   assign retx_last = (retx_cnt_ff + CntW'(1)) == in_flight_ff;

   // next state and result
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      in_flight_in = in_flight_ff;
      full_in      = full_ff;
      rd_ptr_in    = rd_ptr_ff;
      retx_cnt_in  = retx_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = next_ff;
      wr_data      = payload_n;
      rd_en        = 1'b0;
      rd_addr      = rd_ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // default: one status result
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.out_kind    = KIND_STATUS;
               rsp_in.timer_cmd   = TMR_NONE;
               rsp_in.window_full = full_ff;
               rsp_in.last        = 1'b1;
               case (func_type'(req_ch.func))
                  FUNC_SEND: begin
                     if (full_ff || (in_flight_ff >= CntW'(WINDOW))) begin
                        full_in            = 1'b1;
                        rsp_in.out_kind    = KIND_REFUSED;
                        rsp_in.window_full = 1'b1;
                     end else begin
                        wr_en              = 1'b1;
                        next_in            = next_inc;
                        in_flight_in       = flight_inc;
                        full_in            = flight_inc >= CntW'(WINDOW);
                        rsp_in.out_kind    = KIND_NEW;
                        rsp_in.seq_num     = SEQ_W'(next_ff);
                        rsp_in.packet_data = DATA_W'(payload_n);
                        rsp_in.window_full = flight_inc >= CntW'(WINDOW);
                        if (in_flight_ff == '0) begin
                           rsp_in.timer_cmd = TMR_START;
                           rsp_in.timer_seq = SEQ_W'(next_ff);
                        end
                     end
                  end
                  FUNC_ACK: begin
                     if (ack_hit) begin
                        base_in            = ack_base;
                        in_flight_in       = ack_flight;
                        full_in            = 1'b0;
                        rsp_in.ack_taken   = 1'b1;
                        rsp_in.window_full = 1'b0;
                        if (ack_flight == '0) begin
                           rsp_in.timer_cmd = TMR_STOP;
                           rsp_in.timer_seq = SEQ_W'(base_ff);
                        end else begin
                           rsp_in.timer_cmd = TMR_RESTART;
                           rsp_in.timer_seq = SEQ_W'(ack_base);
                        end
                     end
                  end
                  FUNC_TIMEOUT: begin
                     // go back to base: results come from the store walk
                     if (in_flight_ff != '0) begin
                        rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                        rsp_in       = rsp_ff;
                        rd_ptr_in    = base_ff;
                        retx_cnt_in  = '0;
                        state_in     = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.out_kind    = KIND_RETX;
               rsp_in.seq_num     = SEQ_W'(rd_ptr_ff);
               rsp_in.packet_data = DATA_W'(rd_data);
               rsp_in.timer_cmd   = TMR_NONE;
               rsp_in.window_full = full_ff;
               rsp_in.last        = retx_last;
               if (retx_cnt_ff == '0) begin
                  rsp_in.timer_cmd = TMR_RESTART;
                  rsp_in.timer_seq = SEQ_W'(rd_ptr_ff);
               end
               if (retx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_ptr_in   = rd_ptr_inc;
                  retx_cnt_in = retx_cnt_ff + CntW'(1);
                  state_in    = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         next_ff      <= '0;
         in_flight_ff <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         in_flight_ff <= in_flight_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk pointer and result payload
   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      retx_cnt_ff <= retx_cnt_in;
      rsp_ff      <= rsp_in;
   end

   // result channel
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_kind    = rsp_ff.out_kind;
   assign rsp_ch.seq_num     = rsp_ff.seq_num;
   assign rsp_ch.packet_data = rsp_ff.packet_data;
   assign rsp_ch.timer_cmd   = rsp_ff.timer_cmd;
   assign rsp_ch.timer_seq   = rsp_ff.timer_seq;
   assign rsp_ch.ack_taken   = rsp_ff.ack_taken;
   assign rsp_ch.window_full = rsp_ff.window_full;
   assign rsp_ch.last        = rsp_ff.last;

   // checks
   `GBN_ASSERT_IMPLIES(a_flight_bound, clock, reset, 1'b1,
      in_flight_ff <= CntW'(WINDOW), "outstanding count exceeds window")
   `GBN_ASSERT_IMPLIES(a_full_consistent, clock, reset, 1'b1,
      full_ff == (in_flight_ff >= CntW'(WINDOW)), "full flag out of step with count")
   `GBN_ASSERT_IMPLIES(a_retx_in_window, clock, reset, state_ff == ST_EMIT,
      retx_cnt_ff < in_flight_ff, "retransmission walk past outstanding packets")
   `GBN_ASSERT_NEXT(a_fetch_then_emit, clock, reset, state_ff == ST_FETCH,
      state_ff == ST_EMIT && $stable(rd_ptr_ff), "store read not followed by emit")

endmodule

`default_nettype wire

[test/go_back_n_sender_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// go_back_n_sender_checker
// Watches both item channels of the Go-Back-N sender, keeps its own copy of
// the window state and payload store, predicts the results of every accepted
// request item and compares each accepted result item, field by field, with
// the oldest prediction. Failures and outstanding predictions are counted.
// ---------------------------------------------------------------------------

module go_back_n_sender_checker
   import gbn_pkg::*;
(
   input  logic clock,
   input  logic reset,
   gbn_req_if   req_ch,
   gbn_rsp_if   rsp_ch,
   output int   fail_count,
   output int   pending_count
);

   localparam int WINDOW_SIZE = 4;
   localparam int MAX_REPORTS = 10;

   // sender state as predicted
   logic [DATA_W-1:0] pkt_buf [8];
   logic [SEQ_W-1:0]  base_seq;
   logic [SEQ_W-1:0]  tail_seq;
   int unsigned       outstanding;
   logic              refuse_flag;

   rsp_item_type      predicted_q [$];
   int                report_count;

   function automatic rsp_item_type pack_result(kind_type k, logic [SEQ_W-1:0] seq,
                                                logic [DATA_W-1:0] data, timer_type t,
                                                logic [SEQ_W-1:0] tseq, logic taken,
                                                logic lastf);
      rsp_item_type r;
      r.out_kind    = k;
      r.seq_num     = seq;
      r.packet_data = data;
      r.timer_cmd   = t;
      r.timer_seq   = tseq;
      r.ack_taken   = taken;
      r.window_full = refuse_flag;
      r.last        = lastf;
      return r;
   endfunction

   function automatic string show_result(rsp_item_type r);
      return $sformatf("kind=%0d seq=%0d data=%h tcmd=%0d tseq=%0d taken=%b full=%b last=%b",
                       r.out_kind, r.seq_num, r.packet_data, r.timer_cmd, r.timer_seq,
                       r.ack_taken, r.window_full, r.last);
   endfunction

   // advance the predicted state by one request and queue its results
   task automatic predict_sender_results(func_type f, logic [DATA_W-1:0] data,
                                         logic [SEQ_W-1:0] ack, logic ok);
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] ack_gap;
      logic [SEQ_W-1:0] old_base;
      case (f)
         FUNC_SEND: begin
            if (refuse_flag || outstanding >= WINDOW_SIZE) begin
               refuse_flag = 1'b1;
               predicted_q.push_back(pack_result(KIND_REFUSED, '0, '0, TMR_NONE, '0, 1'b0,
                                                 1'b1));
            end else begin
               seq          = tail_seq;
               pkt_buf[seq] = data;
               tail_seq     = seq + 1'b1;
               outstanding++;
               refuse_flag  = (outstanding >= WINDOW_SIZE);
               // the timer starts only when this packet is the only one out
               if (outstanding == 1)
                  predicted_q.push_back(pack_result(KIND_NEW, seq, data, TMR_START, seq,
                                                    1'b0, 1'b1));
               else
                  predicted_q.push_back(pack_result(KIND_NEW, seq, data, TMR_NONE, '0,
                                                    1'b0, 1'b1));
            end
         end
         FUNC_ACK: begin
            ack_gap = ack - base_seq;
            if (!ok || outstanding == 0 || ack_gap >= outstanding) begin
               // corrupt or out-of-window ack: status only
               predicted_q.push_back(pack_result(KIND_STATUS, '0, '0, TMR_NONE, '0, 1'b0,
                                                 1'b1));
            end else begin
               old_base    = base_seq;
               base_seq    = ack + 1'b1;
               outstanding = outstanding - (ack_gap + 1);
               refuse_flag = 1'b0;
               if (outstanding == 0)
                  predicted_q.push_back(pack_result(KIND_STATUS, '0, '0, TMR_STOP, old_base,
                                                    1'b1, 1'b1));
               else
                  predicted_q.push_back(pack_result(KIND_STATUS, '0, '0, TMR_RESTART,
                                                    base_seq, 1'b1, 1'b1));
            end
         end
         FUNC_TIMEOUT: begin
            if (outstanding == 0) begin
               predicted_q.push_back(pack_result(KIND_STATUS, '0, '0, TMR_NONE, '0, 1'b0,
                                                 1'b1));
            end else begin
               // go back: resend every outstanding packet, oldest first
               for (int i = 0; i < outstanding; i++) begin
                  seq = base_seq + SEQ_W'(i);
                  if (i == 0)
                     predicted_q.push_back(pack_result(KIND_RETX, seq, pkt_buf[seq],
                                                       TMR_RESTART, seq, 1'b0,
                                                       outstanding == 1));
                  else
                     predicted_q.push_back(pack_result(KIND_RETX, seq, pkt_buf[seq],
                                                       TMR_NONE, '0, 1'b0,
                                                       i == outstanding - 1));
               end
            end
         end
         default: begin
            predicted_q.push_back(pack_result(KIND_STATUS, '0, '0, TMR_NONE, '0, 1'b0, 1'b1));
         end
      endcase
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         base_seq      = '0;
         tail_seq      = '0;
         outstanding   = 0;
         refuse_flag   = 1'b0;
         predicted_q   = {};
         fail_count    = 0;
         report_count  = 0;
         pending_count = 0;
         for (int i = 0; i < 8; i++)
            pkt_buf[i] = '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_sender_results(func_type'(req_ch.func), req_ch.payload, req_ch.ack_num,
                                   req_ch.ack_ok);

         if (rsp_ch.valid && rsp_ch.ready) begin
            got.out_kind    = kind_type'(rsp_ch.out_kind);
            got.seq_num     = rsp_ch.seq_num;
            got.packet_data = rsp_ch.packet_data;
            got.timer_cmd   = timer_type'(rsp_ch.timer_cmd);
            got.timer_seq   = rsp_ch.timer_seq;
            got.ack_taken   = rsp_ch.ack_taken;
            got.window_full = rsp_ch.window_full;
            got.last        = rsp_ch.last;
            if (predicted_q.size() == 0) begin
               fail_count++;
               if (report_count < MAX_REPORTS)
                  $display("%0t: unexpected result item: %s", $realtime, show_result(got));
               report_count++;
            end else begin
               want = predicted_q.pop_front();
               if (got.out_kind !== want.out_kind || got.seq_num !== want.seq_num ||
                   got.packet_data !== want.packet_data || got.timer_cmd !== want.timer_cmd ||
                   got.timer_seq !== want.timer_seq || got.ack_taken !== want.ack_taken ||
                   got.window_full !== want.window_full || got.last !== want.last) begin
                  fail_count++;
                  if (report_count < MAX_REPORTS) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", show_result(want));
                     $display("   actual   %s", show_result(got));
                  end
                  report_count++;
               end
            end
         end
         pending_count = predicted_q.size();
      end
   end

endmodule

[test/tb_go_back_n_sender_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_go_back_n_sender_unit
// Drives request items into the Go-Back-N sender: a directed run through
// window fill, refusal, go-back retransmission and every kind of ack, then
// random sends, acks, timeouts and unused codes with random gaps on both
// sides. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------

module tb_go_back_n_sender_unit;
   import gbn_pkg::*;

   localparam int RANDOM_ITEMS = 257;
   localparam int MAX_GAP      = 14;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   bit   req_burst;
   bit   rsp_burst;

   gbn_req_if req_ch ();
   gbn_rsp_if rsp_ch ();

   go_back_n_sender_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   go_back_n_sender_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // hard limit on the whole run
   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

   // present one request item at the falling edge and hold it until taken
   task automatic drive_req(func_type f, logic [DATA_W-1:0] data, logic [SEQ_W-1:0] ack,
                            logic ok);
      int gap;
      if ($urandom_range(0, 29) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.func    = f;
      req_ch.payload = data;
      req_ch.ack_num = ack;
      req_ch.ack_ok  = ok;
      req_ch.valid   = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // result side: random stall before each item, with stall-free stretches
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      rsp_burst    = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0)
            rsp_burst = !rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // request stimulus and verdict
   initial begin
      int pick;
      req_ch.valid   = 1'b0;
      req_ch.func    = FUNC_SEND;
      req_ch.payload = '0;
      req_ch.ack_num = '0;
      req_ch.ack_ok  = 1'b0;
      req_burst      = 1'b0;
      reset          = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle cases, fill, refusal, go-back, every ack outcome, wrap
      drive_req(FUNC_TIMEOUT, 32'h0000_0000, 3'd0, 1'b1);
      drive_req(FUNC_ACK,     32'h0000_0000, 3'd0, 1'b1);
      drive_req(FUNC_NOP,     32'hFFFF_FFFF, 3'd7, 1'b1);
      drive_req(FUNC_SEND,    32'h0000_0000, 3'd0, 1'b0);
      drive_req(FUNC_SEND,    32'hFFFF_FFFF, 3'd7, 1'b1);
      drive_req(FUNC_SEND,    32'hA5A5_A5A5, 3'd0, 1'b0);
      drive_req(FUNC_SEND,    32'h5A5A_5A5A, 3'd0, 1'b0);
      drive_req(FUNC_SEND,    32'h1234_5678, 3'd0, 1'b0);
      drive_req(FUNC_TIMEOUT, 32'h0000_0000, 3'd0, 1'b0);
      drive_req(FUNC_ACK,     32'h0000_0000, 3'd1, 1'b0);
      drive_req(FUNC_ACK,     32'h0000_0000, 3'd7, 1'b1);
      drive_req(FUNC_ACK,     32'h0000_0000, 3'd1, 1'b1);
      drive_req(FUNC_SEND,    32'hDEAD_BEEF, 3'd0, 1'b0);
      drive_req(FUNC_SEND,    32'h8000_0001, 3'd0, 1'b0);
      drive_req(FUNC_SEND,    32'h0F0F_0F0F, 3'd0, 1'b0);
      drive_req(FUNC_TIMEOUT, 32'h0000_0000, 3'd0, 1'b0);
      drive_req(FUNC_ACK,     32'h0000_0000, 3'd5, 1'b1);
      drive_req(FUNC_SEND,    32'h7FFF_FFFE, 3'd0, 1'b0);
      drive_req(FUNC_SEND,    32'hC3C3_C3C3, 3'd0, 1'b0);
      drive_req(FUNC_SEND,    32'h3C3C_3C3C, 3'd0, 1'b0);
      drive_req(FUNC_ACK,     32'h0000_0000, 3'd7, 1'b1);
      drive_req(FUNC_ACK,     32'h0000_0000, 3'd0, 1'b1);
      drive_req(FUNC_TIMEOUT, 32'hFFFF_FFFF, 3'd7, 1'b1);

      // random: mostly sends and good acks, some timeouts, bad acks and unused codes
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 48)
            drive_req(FUNC_SEND, $urandom, 3'($urandom), 1'($urandom));
         else if (pick < 83)
            drive_req(FUNC_ACK, $urandom, 3'($urandom_range(0, 7)),
                      $urandom_range(0, 7) != 0);
         else if (pick < 95)
            drive_req(FUNC_TIMEOUT, $urandom, 3'($urandom), 1'($urandom));
         else
            drive_req(FUNC_NOP, $urandom, 3'($urandom), 1'($urandom));
      end
      req_ch.valid = 1'b0;

      // drain, then wait for stray results
      while (pending_count != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
